### design/gbsp_pkg.sv
// ----------------------------------------------------------------------------
// gbsp_pkg
// Types and codes shared by the GIF block stream parser: parse phases,
// byte sections, report kinds, structure bytes and the result record.
// ----------------------------------------------------------------------------
package gbsp_pkg;

    // parse phases, also used as byte section codes
    localparam logic [3:0] PH_SIG      = 4'd0;
    localparam logic [3:0] PH_SCREEN   = 4'd1;
    localparam logic [3:0] PH_GPAL     = 4'd2;
    localparam logic [3:0] PH_INTRO    = 4'd3;
    localparam logic [3:0] PH_EXTLABEL = 4'd4;
    localparam logic [3:0] PH_EXTSIZE  = 4'd5;
    localparam logic [3:0] PH_EXTDATA  = 4'd6;
    localparam logic [3:0] PH_IMGDESC  = 4'd7;
    localparam logic [3:0] PH_LPAL     = 4'd8;
    localparam logic [3:0] PH_LZW      = 4'd9;
    localparam logic [3:0] PH_IMGSIZE  = 4'd10;
    localparam logic [3:0] PH_IMGDATA  = 4'd11;
    localparam logic [3:0] SEC_TRAILER = 4'd12;
    localparam logic [3:0] SEC_UNKNOWN = 4'd13;
    localparam logic [3:0] PH_AFTER    = 4'd14;

    // report kinds
    localparam logic [3:0] RPT_NONE     = 4'd0;
    localparam logic [3:0] RPT_SCREEN   = 4'd1;
    localparam logic [3:0] RPT_PALETTE  = 4'd2;
    localparam logic [3:0] RPT_IMGDESC  = 4'd3;
    localparam logic [3:0] RPT_LZW      = 4'd4;
    localparam logic [3:0] RPT_GCE      = 4'd5;
    localparam logic [3:0] RPT_EXT_END  = 4'd6;
    localparam logic [3:0] RPT_IMG_END  = 4'd7;
    localparam logic [3:0] RPT_TRAILER  = 4'd8;
    localparam logic [3:0] RPT_UNKNOWN  = 4'd9;

    // block introducers and labels
    localparam logic [7:0] INTRO_EXT   = 8'h21;
    localparam logic [7:0] INTRO_IMG   = 8'h2C;
    localparam logic [7:0] INTRO_TRAIL = 8'h3B;
    localparam logic [7:0] LABEL_GCE   = 8'hF9;

    // byte counts of fixed structures
    localparam logic [3:0] SIG_BYTES     = 4'd6;
    localparam logic [3:0] SCREEN_FIELDS = 4'd6;
    localparam logic [3:0] COLOR_FIELDS  = 4'd2;
    localparam logic [3:0] IMG_FIELDS    = 4'd8;
    localparam logic [3:0] GCE_FIELDS    = 4'd4;
    localparam logic [3:0] POS_MAX       = 4'd15;

    typedef struct packed {
        logic [3:0]  section;
        logic [3:0]  report_kind;
        logic [19:0] field_a;
        logic [15:0] field_b;
        logic [15:0] field_c;
        logic [15:0] field_d;
        logic [8:0]  field_e;
        logic [7:0]  packed_flags;
        logic [7:0]  byte_a;
        logic [7:0]  byte_b;
        logic [23:0] data_total;
        logic [23:0] chunk_total;
    } result_t;

    // color table size coded in the low three bits of a packed byte
    function automatic logic [8:0] entries_of(input logic [2:0] code);
        logic [3:0] shamt;
        shamt = {1'b0, code} + 4'd1;
        return 9'd1 << shamt;
    endfunction

endpackage

### design/gif_block_stream_parser.sv
// ----------------------------------------------------------------------------
// gif_block_stream_parser
// Walks the block structure of a GIF file byte by byte, tags each byte with
// its section and reports decoded descriptors, palette entries, graphic
// control fields and data totals.
// ----------------------------------------------------------------------------
// One byte is taken per cycle and gives exactly one result in the next cycle;
// the parse state update and result decode sit between the parse state
// registers and a single result register, so the sustained rate is one byte
// per clock whenever the result side takes its transfers. Byte and sub-block
// totals saturate at 2**COUNT_BITS - 1 and are shown in their low 24 bits.
// ----------------------------------------------------------------------------
module gif_block_stream_parser
    import gbsp_pkg::*;
#(
    parameter int COUNT_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [3:0]  section,
    output logic [3:0]  report_kind,
    output logic [19:0] field_a,
    output logic [15:0] field_b,
    output logic [15:0] field_c,
    output logic [15:0] field_d,
    output logic [8:0]  field_e,
    output logic [7:0]  packed_flags,
    output logic [7:0]  byte_a,
    output logic [7:0]  byte_b,
    output logic [23:0] data_total,
    output logic [23:0] chunk_total
);

    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    logic [3:0]            phase_reg, phase_next;
    logic [3:0]            pos_reg, pos_next;
    logic [7:0]            fb_reg [0:7];
    logic [7:0]            fb_next [0:7];
    logic [8:0]            pal_left_reg, pal_left_next;
    logic [7:0]            pal_idx_reg, pal_idx_next;
    logic [7:0]            sub_left_reg, sub_left_next;
    logic [7:0]            ext_label_reg, ext_label_next;
    logic [COUNT_BITS-1:0] block_num_reg, block_num_next;
    logic [COUNT_BITS-1:0] byte_cnt_reg, byte_cnt_next;
    logic                  result_valid_reg;
    result_t               result_reg, rpt;

    logic                  accept;
    logic                  gce;
    logic [COUNT_BITS:0]   byte_sum;
    logic [COUNT_BITS:0]   block_sum;
    logic [COUNT_BITS-1:0] byte_sat;
    logic [COUNT_BITS-1:0] block_sat;
    logic [31:0]           byte_cnt_wide;
    logic [31:0]           block_num_wide;
    logic [15:0]           delay;
    logic [19:0]           delay_ms;
    logic [7:0]            sub_dec;

    assign data_ready = !result_valid_reg || result_ready;
    assign accept     = data_valid && data_ready;

    assign byte_sum  = {1'b0, byte_cnt_reg} + (COUNT_BITS + 1)'(data_byte);
    assign block_sum = {1'b0, block_num_reg} + (COUNT_BITS + 1)'(1);
    assign byte_sat  = byte_sum[COUNT_BITS] ? '1 : byte_sum[COUNT_BITS-1:0];
    assign block_sat = block_sum[COUNT_BITS] ? '1 : block_sum[COUNT_BITS-1:0];

    assign byte_cnt_wide  = 32'(byte_cnt_reg);
    assign block_num_wide = 32'(block_num_reg);

    assign gce = (phase_reg == PH_EXTDATA) && (ext_label_reg == LABEL_GCE)
                 && (block_num_reg == COUNT_ONE);
    assign sub_dec = (sub_left_reg != 8'd0) ? sub_left_reg - 8'd1 : 8'd0;

    assign delay    = {fb_next[2], fb_next[1]};
    assign delay_ms = ({4'd0, delay} << 3) + ({4'd0, delay} << 1);

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        pal_left_next  = pal_left_reg;
        pal_idx_next   = pal_idx_reg;
        sub_left_next  = sub_left_reg;
        ext_label_next = ext_label_reg;
        block_num_next = block_num_reg;
        byte_cnt_next  = byte_cnt_reg;
        for (int i = 0; i < 8; i++)
        begin
            fb_next[i] = fb_reg[i];
        end
        rpt         = '0;
        rpt.section = phase_reg;

        case (phase_reg)
            PH_SIG:
            begin
                if (pos_reg + 4'd1 >= SIG_BYTES)
                begin
                    pos_next   = 4'd0;
                    phase_next = PH_SCREEN;
                end
                else
                begin
                    pos_next = pos_reg + 4'd1;
                end
            end
            PH_SCREEN:
            begin
                if (pos_reg < SCREEN_FIELDS)
                begin
                    fb_next[pos_reg[2:0]] = data_byte;
                    pos_next = pos_reg + 4'd1;
                end
                else
                begin
                    rpt.report_kind  = RPT_SCREEN;
                    rpt.field_a      = {4'd0, fb_reg[1], fb_reg[0]};
                    rpt.field_b      = {fb_reg[3], fb_reg[2]};
                    rpt.field_c      = {7'd0, entries_of(fb_reg[4][6:4])};
                    rpt.field_d      = {7'd0, entries_of(fb_reg[4][2:0])};
                    rpt.packed_flags = fb_reg[4];
                    rpt.byte_a       = fb_reg[5];
                    rpt.byte_b       = data_byte;
                    pos_next         = 4'd0;
                    pal_idx_next     = 8'd0;
                    if (fb_reg[4][7])
                    begin
                        pal_left_next = entries_of(fb_reg[4][2:0]);
                        phase_next    = PH_GPAL;
                    end
                    else
                    begin
                        phase_next = PH_INTRO;
                    end
                end
            end
            PH_GPAL, PH_LPAL:
            begin
                if (pos_reg < COLOR_FIELDS)
                begin
                    fb_next[pos_reg[2:0]] = data_byte;
                    pos_next = pos_reg + 4'd1;
                end
                else
                begin
                    rpt.report_kind = RPT_PALETTE;
                    rpt.field_a     = {12'd0, pal_idx_reg};
                    rpt.field_b     = {8'd0, fb_reg[0]};
                    rpt.field_c     = {8'd0, fb_reg[1]};
                    rpt.field_d     = {8'd0, data_byte};
                    rpt.byte_a      = {7'd0, phase_reg == PH_LPAL};
                    pos_next        = 4'd0;
                    pal_idx_next    = pal_idx_reg + 8'd1;
                    if (pal_left_reg <= 9'd1)
                    begin
                        pal_left_next = 9'd0;
                        phase_next    = (phase_reg == PH_LPAL) ? PH_LZW : PH_INTRO;
                    end
                    else
                    begin
                        pal_left_next = pal_left_reg - 9'd1;
                    end
                end
            end
            PH_INTRO:
            begin
                if (data_byte == INTRO_TRAIL)
                begin
                    rpt.section     = SEC_TRAILER;
                    rpt.report_kind = RPT_TRAILER;
                    phase_next      = PH_AFTER;
                end
                else if (data_byte == INTRO_EXT)
                begin
                    phase_next = PH_EXTLABEL;
                end
                else if (data_byte == INTRO_IMG)
                begin
                    pos_next   = 4'd0;
                    phase_next = PH_IMGDESC;
                end
                else
                begin
                    rpt.section     = SEC_UNKNOWN;
                    rpt.report_kind = RPT_UNKNOWN;
                    rpt.byte_a      = data_byte;
                end
            end
            PH_EXTLABEL:
            begin
                ext_label_next = data_byte;
                block_num_next = '0;
                byte_cnt_next  = '0;
                phase_next     = PH_EXTSIZE;
            end
            PH_EXTSIZE, PH_IMGSIZE:
            begin
                if (data_byte == 8'd0)
                begin
                    rpt.report_kind = (phase_reg == PH_EXTSIZE) ? RPT_EXT_END : RPT_IMG_END;
                    rpt.byte_a      = (phase_reg == PH_EXTSIZE) ? ext_label_reg : 8'd0;
                    rpt.data_total  = byte_cnt_wide[23:0];
                    rpt.chunk_total = block_num_wide[23:0];
                    phase_next      = PH_INTRO;
                end
                else
                begin
                    sub_left_next  = data_byte;
                    byte_cnt_next  = byte_sat;
                    block_num_next = block_sat;
                    pos_next       = 4'd0;
                    for (int i = 0; i < 4; i++)
                    begin
                        fb_next[i] = 8'd0;
                    end
                    phase_next = (phase_reg == PH_EXTSIZE) ? PH_EXTDATA : PH_IMGDATA;
                end
            end
            PH_EXTDATA, PH_IMGDATA:
            begin
                if (gce && pos_reg < GCE_FIELDS)
                begin
                    fb_next[{1'b0, pos_reg[1:0]}] = data_byte;
                end
                if (pos_reg < POS_MAX)
                begin
                    pos_next = pos_reg + 4'd1;
                end
                sub_left_next = sub_dec;
                if (sub_dec == 8'd0)
                begin
                    if (gce)
                    begin
                        rpt.report_kind  = RPT_GCE;
                        rpt.field_a      = delay_ms;
                        rpt.field_b      = {13'd0, fb_next[0][4:2]};
                        rpt.field_c      = {15'd0, fb_next[0][1]};
                        rpt.field_d      = {15'd0, fb_next[0][0]};
                        rpt.packed_flags = fb_next[0];
                        rpt.byte_a       = fb_next[3];
                    end
                    phase_next = (phase_reg == PH_EXTDATA) ? PH_EXTSIZE : PH_IMGSIZE;
                end
            end
            PH_IMGDESC:
            begin
                if (pos_reg < IMG_FIELDS)
                begin
                    fb_next[pos_reg[2:0]] = data_byte;
                    pos_next = pos_reg + 4'd1;
                end
                else
                begin
                    rpt.report_kind  = RPT_IMGDESC;
                    rpt.field_a      = {4'd0, fb_reg[1], fb_reg[0]};
                    rpt.field_b      = {fb_reg[3], fb_reg[2]};
                    rpt.field_c      = {fb_reg[5], fb_reg[4]};
                    rpt.field_d      = {fb_reg[7], fb_reg[6]};
                    rpt.field_e      = data_byte[7] ? entries_of(data_byte[2:0]) : 9'd0;
                    rpt.packed_flags = data_byte;
                    pos_next         = 4'd0;
                    pal_idx_next     = 8'd0;
                    if (data_byte[7])
                    begin
                        pal_left_next = entries_of(data_byte[2:0]);
                        phase_next    = PH_LPAL;
                    end
                    else
                    begin
                        phase_next = PH_LZW;
                    end
                end
            end
            PH_LZW:
            begin
                rpt.report_kind = RPT_LZW;
                rpt.byte_a      = data_byte;
                block_num_next  = '0;
                byte_cnt_next   = '0;
                phase_next      = PH_IMGSIZE;
            end
            default:
            begin
                rpt.section = PH_AFTER;
                phase_next  = PH_AFTER;
            end
        endcase
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SIG;
            pos_reg       <= 4'd0;
            pal_left_reg  <= 9'd0;
            pal_idx_reg   <= 8'd0;
            sub_left_reg  <= 8'd0;
            ext_label_reg <= 8'd0;
            block_num_reg <= '0;
            byte_cnt_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            pal_left_reg  <= pal_left_next;
            pal_idx_reg   <= pal_idx_next;
            sub_left_reg  <= sub_left_next;
            ext_label_reg <= ext_label_next;
            block_num_reg <= block_num_next;
            byte_cnt_reg  <= byte_cnt_next;
        end
    end

    // field bytes, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 8; i++)
            begin
                fb_reg[i] <= fb_next[i];
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= rpt;
        end
    end

    assign result_valid = result_valid_reg;
    assign section      = result_reg.section;
    assign report_kind  = result_reg.report_kind;
    assign field_a      = result_reg.field_a;
    assign field_b      = result_reg.field_b;
    assign field_c      = result_reg.field_c;
    assign field_d      = result_reg.field_d;
    assign field_e      = result_reg.field_e;
    assign packed_flags = result_reg.packed_flags;
    assign byte_a       = result_reg.byte_a;
    assign byte_b       = result_reg.byte_b;
    assign data_total   = result_reg.data_total;
    assign chunk_total  = result_reg.chunk_total;

    // trailer transfer moves the parser to the after phase
    a_trailer_after: assert property (@(posedge clk) disable iff (!rst_n)
        accept && rpt.report_kind == RPT_TRAILER |=> phase_reg == PH_AFTER)
        else $error("trailer did not end parsing");

    // after phase is final
    a_after_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_AFTER |=> phase_reg == PH_AFTER)
        else $error("parser left after phase");

    // palette phases always have entries left
    a_palette_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_GPAL || phase_reg == PH_LPAL |-> pal_left_reg != 9'd0)
        else $error("palette phase with no entries left");

    // every sub-block holds at least one byte
    a_bytes_vs_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        byte_cnt_reg >= block_num_reg)
        else $error("byte total below sub-block count");

    // a result waiting for transfer is replaced only when it goes out
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_ready |=> result_valid_reg && $stable(result_reg))
        else $error("pending result lost");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gif_block_stream_parser. A directed header walks
// signature, screen descriptor, global palette, stray introducers and an
// empty graphic control extension, then random extensions, images with local
// palettes, data sub-blocks and noise follow, closed by a trailer. A parse
// model in the bench predicts every result transfer and checks it.
// ----------------------------------------------------------------------------
module tb;
    import gbsp_pkg::*;

    localparam int STREAM_BYTES = 1350;

    typedef struct {
        logic [7:0] din;
        bit         typed;
        result_t    want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        data_valid = 1'b0;
    logic        data_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [3:0]  section;
    logic [3:0]  report_kind;
    logic [19:0] field_a;
    logic [15:0] field_b;
    logic [15:0] field_c;
    logic [15:0] field_d;
    logic [8:0]  field_e;
    logic [7:0]  packed_flags;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
    logic [23:0] data_total;
    logic [23:0] chunk_total;

    // parse model state
    logic [3:0]  cur_phase;
    logic [3:0]  cur_pos;
    logic [7:0]  fld [9];
    logic [8:0]  pal_left;
    logic [7:0]  pal_index;
    logic [7:0]  sub_left;
    logic [7:0]  ext_label;
    logic [23:0] chunk_cnt;
    logic [23:0] data_cnt;

    result_t     pending_results [$];
    dir_row_t    dir_rows [$];
    result_t     got_want;
    int          sent_count = 0;
    int          burst_left = 0;
    int          mismatch_count = 0;
    bit          big_palette_done = 1'b0;
    logic [15:0] stall_word = 16'hFFFF;
    logic [6:0]  ready_tick = '0;

    gif_block_stream_parser u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data_byte    (data_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .section      (section),
        .report_kind  (report_kind),
        .field_a      (field_a),
        .field_b      (field_b),
        .field_c      (field_c),
        .field_d      (field_d),
        .field_e      (field_e),
        .packed_flags (packed_flags),
        .byte_a       (byte_a),
        .byte_b       (byte_b),
        .data_total   (data_total),
        .chunk_total  (chunk_total)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [8:0] palette_entries(input logic [2:0] code);
        return 9'd2 << code;
    endfunction

    function automatic logic [23:0] sat_count(input logic [23:0] acc, input logic [7:0] add);
        logic [24:0] sum;
        sum = {1'b0, acc} + {17'b0, add};
        return sum[24] ? 24'hFF_FFFF : sum[23:0];
    endfunction

    function automatic result_t tag_only(input logic [3:0] sec);
        result_t r;
        r = '0;
        r.section = sec;
        return r;
    endfunction

    // advances the parse model by one byte and returns its result
    function automatic result_t parse_byte(input logic [7:0] din);
        result_t    res;
        logic [7:0] pk;
        logic       gce_blk;
        res = '0;
        res.section = cur_phase;
        case (cur_phase)
            PH_SIG:
            begin
                cur_pos = cur_pos + 4'd1;
                if (cur_pos >= SIG_BYTES)
                begin
                    cur_pos = '0;
                    cur_phase = PH_SCREEN;
                end
            end
            PH_SCREEN:
            begin
                if (cur_pos < SCREEN_FIELDS)
                begin
                    fld[cur_pos] = din;
                    cur_pos = cur_pos + 4'd1;
                end
                else
                begin
                    pk = fld[4];
                    res.report_kind = RPT_SCREEN;
                    res.field_a = {4'b0, fld[1], fld[0]};
                    res.field_b = {fld[3], fld[2]};
                    res.field_c = 16'd2 << pk[6:4];
                    res.field_d = {7'b0, palette_entries(pk[2:0])};
                    res.packed_flags = pk;
                    res.byte_a = fld[5];
                    res.byte_b = din;
                    cur_pos = '0;
                    pal_index = '0;
                    if (pk[7])
                    begin
                        pal_left = palette_entries(pk[2:0]);
                        cur_phase = PH_GPAL;
                    end
                    else
                    begin
                        cur_phase = PH_INTRO;
                    end
                end
            end
            PH_GPAL, PH_LPAL:
            begin
                if (cur_pos < COLOR_FIELDS)
                begin
                    fld[cur_pos] = din;
                    cur_pos = cur_pos + 4'd1;
                end
                else
                begin
                    res.report_kind = RPT_PALETTE;
                    res.field_a = {12'b0, pal_index};
                    res.field_b = {8'b0, fld[0]};
                    res.field_c = {8'b0, fld[1]};
                    res.field_d = {8'b0, din};
                    res.byte_a = (cur_phase == PH_LPAL) ? 8'd1 : 8'd0;
                    cur_pos = '0;
                    pal_index = pal_index + 8'd1;
                    if (pal_left > 0)
                        pal_left = pal_left - 9'd1;
                    if (pal_left == 0)
                        cur_phase = (cur_phase == PH_LPAL) ? PH_LZW : PH_INTRO;
                end
            end
            PH_INTRO:
            begin
                if (din == INTRO_TRAIL)
                begin
                    res.section = SEC_TRAILER;
                    res.report_kind = RPT_TRAILER;
                    cur_phase = PH_AFTER;
                end
                else if (din == INTRO_EXT)
                begin
                    cur_phase = PH_EXTLABEL;
                end
                else if (din == INTRO_IMG)
                begin
                    cur_pos = '0;
                    cur_phase = PH_IMGDESC;
                end
                else
                begin
                    res.section = SEC_UNKNOWN;
                    res.report_kind = RPT_UNKNOWN;
                    res.byte_a = din;
                end
            end
            PH_EXTLABEL:
            begin
                ext_label = din;
                chunk_cnt = '0;
                data_cnt = '0;
                cur_phase = PH_EXTSIZE;
            end
            PH_EXTSIZE, PH_IMGSIZE:
            begin
                if (din == 8'h00)
                begin
                    res.report_kind = (cur_phase == PH_EXTSIZE) ? RPT_EXT_END : RPT_IMG_END;
                    res.byte_a = (cur_phase == PH_EXTSIZE) ? ext_label : 8'h00;
                    res.data_total = data_cnt;
                    res.chunk_total = chunk_cnt;
                    cur_phase = PH_INTRO;
                end
                else
                begin
                    sub_left = din;
                    data_cnt = sat_count(data_cnt, din);
                    chunk_cnt = sat_count(chunk_cnt, 8'd1);
                    cur_pos = '0;
                    for (int k = 0; k < 4; k++)
                        fld[k] = 8'h00;
                    cur_phase = (cur_phase == PH_EXTSIZE) ? PH_EXTDATA : PH_IMGDATA;
                end
            end
            PH_EXTDATA, PH_IMGDATA:
            begin
                gce_blk = (cur_phase == PH_EXTDATA) && (ext_label == LABEL_GCE)
                          && (chunk_cnt == 24'd1);
                if (gce_blk && cur_pos < GCE_FIELDS)
                    fld[cur_pos] = din;
                if (cur_pos < POS_MAX)
                    cur_pos = cur_pos + 4'd1;
                if (sub_left > 0)
                    sub_left = sub_left - 8'd1;
                if (sub_left == 0)
                begin
                    if (gce_blk)
                    begin
                        pk = fld[0];
                        res.report_kind = RPT_GCE;
                        res.field_a = 20'({fld[2], fld[1]}) * 20'd10;
                        res.field_b = {13'b0, pk[4:2]};
                        res.field_c = {15'b0, pk[1]};
                        res.field_d = {15'b0, pk[0]};
                        res.packed_flags = pk;
                        res.byte_a = fld[3];
                    end
                    cur_phase = (cur_phase == PH_EXTDATA) ? PH_EXTSIZE : PH_IMGSIZE;
                end
            end
            PH_IMGDESC:
            begin
                if (cur_pos < IMG_FIELDS)
                begin
                    fld[cur_pos] = din;
                    cur_pos = cur_pos + 4'd1;
                end
                else
                begin
                    res.report_kind = RPT_IMGDESC;
                    res.field_a = {4'b0, fld[1], fld[0]};
                    res.field_b = {fld[3], fld[2]};
                    res.field_c = {fld[5], fld[4]};
                    res.field_d = {fld[7], fld[6]};
                    fld[8] = din;
                    res.field_e = din[7] ? palette_entries(din[2:0]) : 9'd0;
                    res.packed_flags = din;
                    cur_pos = '0;
                    pal_index = '0;
                    if (din[7])
                    begin
                        pal_left = palette_entries(din[2:0]);
                        cur_phase = PH_LPAL;
                    end
                    else
                    begin
                        cur_phase = PH_LZW;
                    end
                end
            end
            PH_LZW:
            begin
                res.report_kind = RPT_LZW;
                res.byte_a = din;
                chunk_cnt = '0;
                data_cnt = '0;
                cur_phase = PH_IMGSIZE;
            end
            default:
            begin
                res.section = PH_AFTER;
                cur_phase = PH_AFTER;
            end
        endcase
        return res;
    endfunction

    task automatic send_byte(input logic [7:0] value);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                data_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        data_valid <= 1'b1;
        data_byte <= value;
        do
            @(posedge clk);
        while (!data_ready);
        sent_count++;
        pending_results.push_back(parse_byte(value));
    endtask

    task automatic add_row(input logic [7:0] din, input bit typed, input result_t want);
        dir_row_t row;
        row.din = din;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    function automatic int data_len();
        int pick;
        pick = $urandom_range(0, 39);
        if (pick == 0)
            return 255;
        else if (pick < 5)
            return $urandom_range(7, 40);
        return $urandom_range(1, 6);
    endfunction

    task automatic send_data_blocks(input bit gce_like);
        int n;
        int len;
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++)
        begin
            len = (gce_like && k == 0 && $urandom_range(0, 2) != 0) ? 4 : data_len();
            send_byte(8'(len));
            repeat (len) send_byte(8'($urandom));
        end
        send_byte(8'h00);
    endtask

    task automatic send_extension();
        logic [7:0] label;
        send_byte(INTRO_EXT);
        label = ($urandom_range(0, 2) != 0) ? LABEL_GCE : 8'($urandom);
        send_byte(label);
        send_data_blocks(label == LABEL_GCE);
    endtask

    task automatic send_image();
        logic [7:0] flags;
        send_byte(INTRO_IMG);
        repeat (8) send_byte(8'($urandom));
        flags = 8'($urandom);
        if (!big_palette_done && sent_count >= 300)
        begin
            flags[7] = 1'b1;
            flags[2:0] = 3'd7;
            big_palette_done = 1'b1;
        end
        else if (flags[7])
        begin
            flags[2:0] = 3'($urandom_range(0, 2));
        end
        send_byte(flags);
        if (flags[7])
            repeat (3 * (2 << flags[2:0])) send_byte(8'($urandom));
        send_byte(8'($urandom));
        send_data_blocks(1'b0);
    endtask

    task automatic send_noise();
        logic [7:0] junk;
        repeat ($urandom_range(1, 3))
        begin
            do
                junk = 8'($urandom);
            while (junk == INTRO_EXT || junk == INTRO_IMG || junk == INTRO_TRAIL);
            send_byte(junk);
        end
    endtask

    // result side stalls on a pattern that is reloaded each time ready_tick wraps
    always @(posedge clk)
    begin
        ready_tick <= ready_tick + 7'd1;
        if (ready_tick == '0)
        begin
            if ($urandom_range(0, 3) == 0)
                stall_word <= 16'hFFFF;
            else
                stall_word <= 16'($urandom) | 16'h0101;
        end
        result_ready <= stall_word[ready_tick[3:0]];
    end

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing pending");
                mismatch_count++;
            end
            else
            begin
                got_want = pending_results.pop_front();
                check_field("section", 24'(got_want.section), 24'(section));
                check_field("report_kind", 24'(got_want.report_kind), 24'(report_kind));
                check_field("field_a", 24'(got_want.field_a), 24'(field_a));
                check_field("field_b", 24'(got_want.field_b), 24'(field_b));
                check_field("field_c", 24'(got_want.field_c), 24'(field_c));
                check_field("field_d", 24'(got_want.field_d), 24'(field_d));
                check_field("field_e", 24'(got_want.field_e), 24'(field_e));
                check_field("packed_flags", 24'(got_want.packed_flags), 24'(packed_flags));
                check_field("byte_a", 24'(got_want.byte_a), 24'(byte_a));
                check_field("byte_b", 24'(got_want.byte_b), 24'(byte_b));
                check_field("data_total", got_want.data_total, data_total);
                check_field("chunk_total", got_want.chunk_total, chunk_total);
            end
        end
    end

    initial
    begin
        result_t rep;
        int      pick;

        cur_phase = PH_SIG;
        cur_pos = '0;
        pal_left = '0;
        pal_index = '0;
        sub_left = '0;
        ext_label = '0;
        chunk_cnt = '0;
        data_cnt = '0;
        for (int k = 0; k < 9; k++)
            fld[k] = 8'h00;

        // signature bytes are checked only for their section tag, with no report
        add_row(8'h00, 1'b1, tag_only(PH_SIG));
        add_row(8'hFF, 1'b1, tag_only(PH_SIG));
        add_row(8'h46, 1'b1, tag_only(PH_SIG));
        add_row(8'h38, 1'b1, tag_only(PH_SIG));
        add_row(8'h39, 1'b1, tag_only(PH_SIG));
        add_row(8'h61, 1'b1, tag_only(PH_SIG));
        // screen: max width, zero height, two-entry global palette
        add_row(8'hFF, 1'b1, tag_only(PH_SCREEN));
        add_row(8'hFF, 1'b1, tag_only(PH_SCREEN));
        add_row(8'h00, 1'b1, tag_only(PH_SCREEN));
        add_row(8'h00, 1'b1, tag_only(PH_SCREEN));
        add_row(8'hF0, 1'b1, tag_only(PH_SCREEN));
        add_row(8'hFF, 1'b1, tag_only(PH_SCREEN));
        rep = '{section: PH_SCREEN, report_kind: RPT_SCREEN, field_a: 20'h0FFFF,
                field_c: 16'd256, field_d: 16'd2, packed_flags: 8'hF0,
                byte_a: 8'hFF, default: '0};
        add_row(8'h00, 1'b1, rep);
        add_row(8'h00, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(8'hFF, 1'b0, '0);
        add_row(8'hFF, 1'b0, '0);
        add_row(8'hFF, 1'b0, '0);
        // stray introducers
        rep = '{section: SEC_UNKNOWN, report_kind: RPT_UNKNOWN, default: '0};
        add_row(8'h00, 1'b1, rep);
        rep.byte_a = 8'hFF;
        add_row(8'hFF, 1'b1, rep);
        // empty graphic control extension gives no gce report
        add_row(INTRO_EXT, 1'b0, '0);
        add_row(LABEL_GCE, 1'b0, '0);
        rep = '{section: PH_EXTSIZE, report_kind: RPT_EXT_END, byte_a: LABEL_GCE,
                default: '0};
        add_row(8'h00, 1'b1, rep);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            send_byte(dir_rows[i].din);
            if (dir_rows[i].typed)
                pending_results[pending_results.size() - 1] = dir_rows[i].want;
        end

        while (sent_count < STREAM_BYTES)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                send_extension();
            else if (pick < 8)
                send_image();
            else
                send_noise();
        end

        // trailer, then bytes past the end of the file
        send_byte(INTRO_TRAIL);
        send_byte(INTRO_EXT);
        send_byte(INTRO_TRAIL);
        repeat (3) send_byte(8'($urandom));
        data_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
design/gbsp_pkg.sv
design/gif_block_stream_parser.sv
tb/tb.sv
